// File: rtl/cceo_pkg.sv
package cceo_pkg;

   // Table geometry and field widths
   localparam int CLUSTERS            = 4096;
   localparam int ENTRIES_PER_CLUSTER = 8;
   localparam int ENTRY_BYTES         = 64;

   localparam int CLUSTER_W  = 12;
   localparam int INDEX_W    = 16;
   localparam int BPC_W      = 17;
   localparam int OFFSET_W   = 28;
   localparam int PRODUCT_W  = BPC_W + CLUSTER_W;
   localparam int ADDR_W     = $clog2(CLUSTERS);
   localparam int WITHIN_W   = (ENTRIES_PER_CLUSTER > 1) ? $clog2(ENTRIES_PER_CLUSTER) : 1;
   localparam int HOP_W      = INDEX_W;

   localparam logic [CLUSTER_W-1:0] CHAIN_END = {CLUSTER_W{1'b1}};
   localparam logic [BPC_W-1:0]     BPC_RESET = BPC_W'(512);

   // Operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic                 operation;
      logic [CLUSTER_W-1:0] cluster;
      logic [INDEX_W-1:0]   entry_index;
      logic [CLUSTER_W-1:0] next_cluster;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic                past_end;
   } rsp_type;

endpackage

// File: rtl/cceo_ram.sv
module cceo_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/cluster_chain_entry_offset_core.sv
// Cluster chain walk: link table plus entry-to-byte-offset translation.
// Input words are taken on start while busy is low. A write word (operation
// 0) stores one link into the table in its accept cycle and gives no result;
// busy stays low, so writes stream one per cycle. A lookup word (operation 1)
// walks the chain from the start cluster, one table read per cluster hop,
// where hops = entry_index / 8. Each hop is a read through the table's
// registered read port; then the MUL step multiplies the cluster number by
// the cluster size and the FIN step adds the in-cluster position; an index
// in the first cluster skips the walk. The result word is registered after
// FIN and shows on rsp_data with rsp_strobe for one cycle. busy is high from
// the cycle after accept until the cycle before the strobe. An end-of-chain
// link met during the walk ends it early with offset 0 and past_end set.
// The receiver cannot stall; rsp_data keeps a result until the next one.
// The cluster size register (csr_) is always ready and the user must write it
// only while the block is idle; the block does not check this. Reset returns
// control to idle, cluster size to 512; table contents unknown until written.
module cluster_chain_entry_offset_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  cceo_pkg::req_type         req_data,
   output logic                      rsp_strobe,
   output cceo_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [cceo_pkg::BPC_W-1:0] csr_data
);

   import cceo_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [HOP_W-1:0]     hops_ff, hops_in;
   logic [CLUSTER_W-1:0] cur_ff, cur_in;
   logic [WITHIN_W-1:0]  within_ff, within_in;
   logic                 past_ff, past_in;
   logic [PRODUCT_W-1:0] prod_ff, prod_in;
   logic [BPC_W-1:0]     bpc_ff, bpc_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 ram_we, ram_re;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [CLUSTER_W-1:0] ram_rdata;
   logic [HOP_W-1:0]     req_hops;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign req_hops = HOP_W'(req_data.entry_index / ENTRIES_PER_CLUSTER);

   // link table
   assign ram_we = accept && (req_data.operation == OP_WRITE);

   cceo_ram #(
      .WIDTH (CLUSTER_W),
      .DEPTH (CLUSTERS)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(req_data.cluster)),
      .wdata (req_data.next_cluster),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // cluster size register
   assign csr_ready = 1'b1;
   assign bpc_in    = (csr_valid && csr_ready) ? csr_data : bpc_ff;

   // chain walk sequencer
   always_comb begin
      state_in      = state_ff;
      hops_in       = hops_ff;
      cur_in        = cur_ff;
      within_in     = within_ff;
      past_in       = past_ff;
      prod_in       = prod_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_re        = 1'b0;
      ram_raddr     = ADDR_W'(req_data.cluster);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.operation == OP_LOOKUP)) begin
               cur_in    = req_data.cluster;
               hops_in   = req_hops;
               within_in = WITHIN_W'(req_data.entry_index % ENTRIES_PER_CLUSTER);
               past_in   = 1'b0;
               if (req_hops == '0) begin
                  state_in = ST_MUL;
               end else begin
                  ram_re   = 1'b1;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // link for cur_ff is on the read port now
            ram_raddr = ADDR_W'(ram_rdata);
            if (ram_rdata == CHAIN_END) begin
               past_in  = 1'b1;
               state_in = ST_FIN;
            end else begin
               cur_in  = ram_rdata;
               hops_in = hops_ff - 1'b1;
               if (hops_ff == HOP_W'(1)) begin
                  state_in = ST_MUL;
               end else begin
                  ram_re = 1'b1;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PRODUCT_W'(bpc_ff) * PRODUCT_W'(cur_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rsp_strobe_in = 1'b1;
            if (past_ff) begin
               rsp_in.byte_offset = '0;
               rsp_in.past_end    = 1'b1;
            end else begin
               rsp_in.byte_offset = prod_ff[OFFSET_W-1:0]
                                  + OFFSET_W'(within_ff * ENTRY_BYTES);
               rsp_in.past_end    = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         bpc_ff        <= BPC_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         bpc_ff        <= bpc_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      hops_ff   <= hops_in;
      cur_ff    <= cur_in;
      within_ff <= within_in;
      past_ff   <= past_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // checks
   a_strobe_after_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_FIN))
      else $error("result strobe without a finishing step");

   a_past_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.past_end) |-> (rsp_data.byte_offset == '0))
      else $error("past-end result with nonzero offset");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("table write during a walk");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.operation == OP_LOOKUP)) |=> busy)
      else $error("lookup accepted but block not busy");

endmodule
